[design/m4inv_pkg.sv]
// Package for the 4x4 matrix inverse unit: widths, sequencer states and the
// cofactor index helpers. No dependencies.
package m4inv_pkg;

    localparam int FRAC_BITS = 16;
    localparam int ELEM_W    = 32;
    localparam int THR_W     = 31;
    localparam int COF_W     = 100;
    localparam int ACC_W     = 128;
    localparam int MUL_W     = 2 * (ELEM_W + 1);
    localparam int QB        = ELEM_W + 1;
    localparam int STEP_W    = $clog2(QB);

    typedef enum logic [4:0] {
        S_IDLE,
        S_T0, S_T1, S_T2, S_T3, S_T4, S_T5, S_T6, S_CWR,
        S_D0, S_D1, S_D2, S_D3, S_D4, S_D5, S_D6,
        S_K0, S_K1, S_K2,
        S_V0, S_V1, S_V2, S_DIV, S_RND, S_SAT, S_OUT
    } state_t;

    // Shift codes for the accumulator add: 0, 32 or 64 bits
    typedef enum logic [1:0] {
        SH_0,
        SH_32,
        SH_64
    } shift_t;

    // Map a minor index onto the full index, skipping the deleted line
    function automatic logic [1:0] skip_map(input logic [1:0] a, input logic [1:0] skip);
        return (a >= skip) ? a + 2'd1 : a;
    endfunction

    // Column choice of each of the six terms of a 3x3 determinant, {c2, c1, c0}
    function automatic logic [5:0] perm_cols(input logic [2:0] term);
        logic [5:0] cols;
        case (term)
            3'd0:    cols = 6'b10_01_00;
            3'd1:    cols = 6'b01_10_00;
            3'd2:    cols = 6'b10_00_01;
            3'd3:    cols = 6'b00_10_01;
            3'd4:    cols = 6'b01_00_10;
            default: cols = 6'b00_01_10;
        endcase
        return cols;
    endfunction

    // Odd permutations carry a minus sign
    function automatic logic perm_neg(input logic [2:0] term);
        return (term == 3'd1) || (term == 3'd2) || (term == 3'd5);
    endfunction

    // Store address of factor a of a term of the minor of entry rc = {row, col}
    function automatic logic [3:0] minor_addr(input logic [3:0] rc, input logic [2:0] term,
                                              input logic [1:0] a);
        logic [5:0] cols;
        logic [1:0] mcol;
        cols = perm_cols(term);
        mcol = cols[2 * a +: 2];
        return {skip_map(a, rc[3:2]), skip_map(mcol, rc[1:0])};
    endfunction

endpackage

[design/m4inv_req_if.sv]
// Request channel of the inverse unit: one matrix element per request.
// Depends on m4inv_pkg.
interface m4inv_req_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [m4inv_pkg::ELEM_W-1:0]    element_value;
    logic [1:0]                             elem_row;
    logic [1:0]                             elem_col;
    logic                                   last_element;

    modport source (output valid, element_value, elem_row, elem_col, last_element,
                    input ready);
    modport sink   (input valid, element_value, elem_row, elem_col, last_element,
                    output ready);
endinterface

[design/m4inv_rsp_if.sv]
// Result channel of the inverse unit: one inverse element per transfer.
// Depends on m4inv_pkg.
interface m4inv_rsp_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [m4inv_pkg::ELEM_W-1:0]    inverse_value;
    logic [1:0]                             out_row;
    logic [1:0]                             out_col;
    logic                                   singular;
    logic                                   overflow;
    logic                                   last_result;

    modport source (output valid, inverse_value, out_row, out_col, singular, overflow,
                    last_result, input ready);
    modport sink   (input valid, inverse_value, out_row, out_col, singular, overflow,
                    last_result, output ready);
endinterface

[design/m4inv_cfg_if.sv]
// Configuration write channel: threshold register data with valid and ready.
// Depends on m4inv_pkg.
interface m4inv_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [m4inv_pkg::THR_W-1:0]        data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

[design/matrix4_inverse_adjoint_unit.sv]
// Top level of the 4x4 matrix inverse unit (adjugate over determinant).
// Depends on m4inv_pkg, m4inv_req_if, m4inv_rsp_if and m4inv_cfg_if.
//
//   channel | dir | carries
//   --------+-----+--------------------------------------------------------
//   req     | in  | element_value, elem_row, elem_col, last_element
//   rsp     | out | inverse_value, out_row, out_col, singular, overflow,
//           |     | last_result
//   cfg     | in  | det_threshold write data
//
// Each request writes one element while the sequencer is idle. The last one
// starts the sequencer on the one shared 33x33 multiplier: the 16 cofactors,
// each a sum of six product terms stepped through states S_T0 to S_T6, then
// the determinant, then a bit-serial divider for each result element, with
// rsp stalls holding the sequencer. req is taken only while the sequencer is
// idle; the result register lets a new matrix load while the final result
// still waits. No clearing pass after reset.
module matrix4_inverse_adjoint_unit (
    input  logic         clk,
    input  logic         rst_n,
    m4inv_req_if.sink    req,
    m4inv_rsp_if.source  rsp,
    m4inv_cfg_if.sink    cfg
);
    import m4inv_pkg::*;

    // Memories
    logic [ELEM_W-1:0]      mat_mem [16];
    logic [COF_W-1:0]       cof_mem [16];
    logic [3:0]             mat_raddr;
    logic [3:0]             cof_raddr;
    logic [ELEM_W-1:0]      mat_rdata_reg;
    logic [COF_W-1:0]       cof_rdata_reg;
    logic                   cof_we;

    // Sequencer state
    state_t                 state_reg, state_next;
    logic [3:0]             cnt_reg, cnt_next;
    logic [2:0]             term_reg, term_next;
    logic [STEP_W-1:0]      step_reg, step_next;

    // Datapath
    logic                   mul_en;
    logic signed [ELEM_W:0] mul_a, mul_b;
    logic signed [MUL_W-1:0] mul_reg;
    logic                   add_en, add_neg, acc_clr;
    shift_t                 add_sh;
    logic signed [ACC_W-1:0] acc_reg, acc_next, addend;
    logic [ELEM_W-1:0]      opa_reg, opa_next, opc_reg, opc_next;
    logic [2*ELEM_W-1:0]    ab_reg, ab_next;
    logic [ACC_W-1:0]       tmp_reg, tmp_next;
    logic                   neg_reg, neg_next;
    logic signed [ACC_W-1:0] det_reg, det_next;
    logic [ACC_W-1:0]       dmag_reg, dmag_next;
    logic [ACC_W-1:0]       rem_reg, rem_next;
    logic [QB-1:0]          low_reg, low_next;
    logic [QB:0]            q_reg, q_next;
    logic                   ovf_reg, ovf_next;
    logic                   sing_reg, sing_next;
    logic [ELEM_W-1:0]      res_reg, res_next;
    logic [THR_W-1:0]       thr_reg;
    logic                   out_load;

    // Result register
    logic                   rsp_valid_reg;
    logic [ELEM_W-1:0]      rsp_value_reg;
    logic [1:0]             rsp_row_reg, rsp_col_reg;
    logic                   rsp_sing_reg, rsp_ovf_reg, rsp_last_reg;

    // Helpers for the combinational block
    logic [COF_W-1:0]       cf_abs;
    logic [ACC_W:0]         r2;
    logic [QB:0]            limit;
    logic [ELEM_W-1:0]      sat_val;
    logic                   sat_ovf;

    assign req.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.inverse_value = rsp_value_reg;
    assign rsp.out_row       = rsp_row_reg;
    assign rsp.out_col       = rsp_col_reg;
    assign rsp.singular      = rsp_sing_reg;
    assign rsp.overflow      = rsp_ovf_reg;
    assign rsp.last_result   = rsp_last_reg;

    // Matrix store: written by requests, one registered read port
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            mat_mem[{req.elem_row, req.elem_col}] <= req.element_value;
        end
        mat_rdata_reg <= mat_mem[mat_raddr];
    end

    // Cofactor store: written by the sequencer, one registered read port
    always_ff @(posedge clk)
    begin
        if (cof_we)
        begin
            cof_mem[cnt_reg] <= acc_reg[COF_W-1:0];
        end
        cof_rdata_reg <= cof_mem[cof_raddr];
    end

    // Shared multiplier, registered
    always_ff @(posedge clk)
    begin
        if (mul_en)
        begin
            mul_reg <= mul_a * mul_b;
        end
    end

    // Accumulator add of the shifted product
    always_comb
    begin
        addend = ACC_W'(mul_reg);
        case (add_sh)
            SH_32:   addend = addend <<< 32;
            SH_64:   addend = addend <<< 64;
            default: addend = addend;
        endcase
        acc_next = acc_reg;
        if (acc_clr)
        begin
            acc_next = '0;
        end
        else if (add_en)
        begin
            acc_next = add_neg ? acc_reg - addend : acc_reg + addend;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            term_reg      <= '0;
            step_reg      <= '0;
            thr_reg       <= THR_W'(1);
            rsp_valid_reg <= 1'b0;
            det_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            term_reg  <= term_next;
            step_reg  <= step_next;
            det_reg   <= det_next;
            if (cfg.valid)
            begin
                thr_reg <= cfg.data;
            end
            if (out_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        opa_reg  <= opa_next;
        opc_reg  <= opc_next;
        ab_reg   <= ab_next;
        tmp_reg  <= tmp_next;
        neg_reg  <= neg_next;
        dmag_reg <= dmag_next;
        rem_reg  <= rem_next;
        low_reg  <= low_next;
        q_reg    <= q_next;
        ovf_reg  <= ovf_next;
        sing_reg <= sing_next;
        res_reg  <= res_next;
        if (out_load)
        begin
            rsp_value_reg <= res_reg;
            rsp_row_reg   <= sing_reg ? 2'd0 : cnt_reg[3:2];
            rsp_col_reg   <= sing_reg ? 2'd0 : cnt_reg[1:0];
            rsp_sing_reg  <= sing_reg;
            rsp_ovf_reg   <= ovf_reg;
            rsp_last_reg  <= sing_reg || (cnt_reg == 4'd15);
        end
    end

    // Sequencer: next state and datapath control
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        term_next  = term_reg;
        step_next  = step_reg;
        mat_raddr  = '0;
        cof_raddr  = '0;
        cof_we     = 1'b0;
        mul_en     = 1'b0;
        mul_a      = '0;
        mul_b      = $signed(opc_reg);
        add_en     = 1'b0;
        add_neg    = neg_reg;
        add_sh     = SH_0;
        acc_clr    = 1'b0;
        opa_next   = opa_reg;
        opc_next   = opc_reg;
        ab_next    = ab_reg;
        tmp_next   = tmp_reg;
        neg_next   = neg_reg;
        det_next   = det_reg;
        dmag_next  = dmag_reg;
        rem_next   = rem_reg;
        low_next   = low_reg;
        q_next     = q_reg;
        ovf_next   = ovf_reg;
        sing_next  = sing_reg;
        res_next   = res_reg;
        out_load   = 1'b0;
        cf_abs     = cof_rdata_reg[COF_W-1] ? COF_W'(-cof_rdata_reg) : cof_rdata_reg;
        r2         = {rem_reg, low_reg[QB-1]};
        limit      = neg_reg ? (QB+1)'(1) << (ELEM_W - 1) : ((QB+1)'(1) << (ELEM_W - 1)) - 1'b1;
        sat_ovf    = ovf_reg || (q_reg > limit);
        sat_val    = sat_ovf ? limit[ELEM_W-1:0] : q_reg[ELEM_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid && req.last_element)
                begin
                    cnt_next   = '0;
                    term_next  = '0;
                    acc_clr    = 1'b1;
                    state_next = S_T0;
                end
            end
            // One product term of a 3x3 minor: read three factors, multiply
            S_T0:
            begin
                mat_raddr  = minor_addr(cnt_reg, term_reg, 2'd0);
                state_next = S_T1;
            end
            S_T1:
            begin
                opa_next   = mat_rdata_reg;
                mat_raddr  = minor_addr(cnt_reg, term_reg, 2'd1);
                state_next = S_T2;
            end
            S_T2:
            begin
                mul_en     = 1'b1;
                mul_a      = $signed({opa_reg[ELEM_W-1], opa_reg});
                mul_b      = $signed({mat_rdata_reg[ELEM_W-1], mat_rdata_reg});
                mat_raddr  = minor_addr(cnt_reg, term_reg, 2'd2);
                state_next = S_T3;
            end
            S_T3:
            begin
                ab_next    = mul_reg[2*ELEM_W-1:0];
                opc_next   = mat_rdata_reg;
                neg_next   = perm_neg(term_reg) ^ cnt_reg[2] ^ cnt_reg[0];
                state_next = S_T4;
            end
            S_T4:
            begin
                mul_en     = 1'b1;
                mul_a      = $signed({1'b0, ab_reg[ELEM_W-1:0]});
                state_next = S_T5;
            end
            S_T5:
            begin
                add_en     = 1'b1;
                mul_en     = 1'b1;
                mul_a      = $signed({ab_reg[2*ELEM_W-1], ab_reg[2*ELEM_W-1:ELEM_W]});
                state_next = S_T6;
            end
            S_T6:
            begin
                add_en = 1'b1;
                add_sh = SH_32;
                if (term_reg == 3'd5)
                begin
                    state_next = S_CWR;
                end
                else
                begin
                    term_next  = term_reg + 3'd1;
                    state_next = S_T0;
                end
            end
            // Store the finished cofactor and move on
            S_CWR:
            begin
                cof_we    = 1'b1;
                acc_clr   = 1'b1;
                term_next = '0;
                cnt_next  = cnt_reg + 4'd1;
                state_next = (cnt_reg == 4'd15) ? S_D0 : S_T0;
            end
            // Determinant along row 0 with rounded cofactors
            S_D0:
            begin
                mat_raddr  = {2'b00, cnt_reg[1:0]};
                cof_raddr  = {2'b00, cnt_reg[1:0]};
                state_next = S_D1;
            end
            S_D1:
            begin
                tmp_next   = ACC_W'(cf_abs);
                neg_next   = cof_rdata_reg[COF_W-1];
                opc_next   = mat_rdata_reg;
                state_next = S_D2;
            end
            S_D2:
            begin
                tmp_next   = (tmp_reg + (ACC_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
                state_next = S_D3;
            end
            S_D3:
            begin
                mul_en     = 1'b1;
                mul_a      = $signed({1'b0, tmp_reg[ELEM_W-1:0]});
                state_next = S_D4;
            end
            S_D4:
            begin
                add_en     = 1'b1;
                mul_en     = 1'b1;
                mul_a      = $signed({1'b0, tmp_reg[2*ELEM_W-1:ELEM_W]});
                state_next = S_D5;
            end
            S_D5:
            begin
                add_en     = 1'b1;
                add_sh     = SH_32;
                mul_en     = 1'b1;
                mul_a      = $signed({1'b0, tmp_reg[3*ELEM_W-1:2*ELEM_W]});
                state_next = S_D6;
            end
            S_D6:
            begin
                add_en = 1'b1;
                add_sh = SH_64;
                if (cnt_reg[1:0] == 2'd3)
                begin
                    state_next = S_K0;
                end
                else
                begin
                    cnt_next   = cnt_reg + 4'd1;
                    state_next = S_D0;
                end
            end
            // Singular test on the rounded magnitude
            S_K0:
            begin
                det_next   = acc_reg;
                dmag_next  = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
                state_next = S_K1;
            end
            S_K1:
            begin
                tmp_next   = (dmag_reg + (ACC_W'(1) << (2 * FRAC_BITS - 1))) >> (2 * FRAC_BITS);
                state_next = S_K2;
            end
            S_K2:
            begin
                cnt_next = '0;
                if ((dmag_reg == '0) || (tmp_reg < ACC_W'(thr_reg)))
                begin
                    sing_next  = 1'b1;
                    ovf_next   = 1'b0;
                    res_next   = '0;
                    state_next = S_OUT;
                end
                else
                begin
                    sing_next  = 1'b0;
                    state_next = S_V0;
                end
            end
            // Result element (i, j) from the transposed cofactor
            S_V0:
            begin
                cof_raddr  = {cnt_reg[1:0], cnt_reg[3:2]};
                state_next = S_V1;
            end
            S_V1:
            begin
                neg_next   = cof_rdata_reg[COF_W-1] ^ det_reg[ACC_W-1];
                tmp_next   = ACC_W'(cf_abs) << FRAC_BITS;
                state_next = S_V2;
            end
            S_V2:
            begin
                q_next    = '0;
                step_next = '0;
                if ((tmp_reg >> QB) >= dmag_reg)
                begin
                    ovf_next   = 1'b1;
                    state_next = S_SAT;
                end
                else
                begin
                    ovf_next   = 1'b0;
                    rem_next   = tmp_reg >> QB;
                    low_next   = tmp_reg[QB-1:0];
                    state_next = S_DIV;
                end
            end
            // Restoring division, one quotient bit a cycle
            S_DIV:
            begin
                if (r2 >= {1'b0, dmag_reg})
                begin
                    rem_next = ACC_W'(r2 - {1'b0, dmag_reg});
                    q_next   = {q_reg[QB-1:0], 1'b1};
                end
                else
                begin
                    rem_next = r2[ACC_W-1:0];
                    q_next   = {q_reg[QB-1:0], 1'b0};
                end
                low_next  = low_reg << 1;
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(QB - 1))
                begin
                    state_next = S_RND;
                end
            end
            S_RND:
            begin
                if ({rem_reg, 1'b0} >= {1'b0, dmag_reg})
                begin
                    q_next = q_reg + 1'b1;
                end
                state_next = S_SAT;
            end
            S_SAT:
            begin
                ovf_next   = sat_ovf;
                res_next   = neg_reg ? -sat_val : sat_val;
                state_next = S_OUT;
            end
            // Hand the element to the result register when it is free
            S_OUT:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    out_load = 1'b1;
                    if (sing_reg || (cnt_reg == 4'd15))
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cnt_next   = cnt_reg + 4'd1;
                        state_next = S_V0;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_div_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (rem_reg < dmag_reg))
        else $error("division remainder not below divisor");

    a_singular_form: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.singular) |->
            (rsp.last_result && !rsp.overflow && (rsp.inverse_value == '0)))
        else $error("singular result malformed");

    a_overflow_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.overflow) |->
            ((rsp.inverse_value == 32'sh7FFF_FFFF) || (rsp.inverse_value == 32'sh8000_0000)))
        else $error("overflow result not at the saturation limit");
`endif

endmodule

[sim/matrix4_inverse_adjoint_unit_test.sv]
// Testbench for matrix4_inverse_adjoint_unit: loads matrices, predicts the adjugate inverse
// with wide exact arithmetic and checks every result element in order.
// Depends on m4inv_pkg, m4inv_req_if, m4inv_rsp_if, m4inv_cfg_if and the unit itself.
module matrix4_inverse_adjoint_unit_test;
    timeunit 1ns;
    timeprecision 1ps;
    import m4inv_pkg::*;

    typedef struct {
        logic signed [ELEM_W-1:0] value;
        logic [1:0]               row;
        logic [1:0]               col;
        logic                     singular;
        logic                     overflow;
        logic                     last;
    } inv_elem_t;

    typedef struct {
        logic [31:0] value;
        logic [1:0]  row;
        logic [1:0]  col;
        logic        last;
        logic        typed_singular;
    } load_row_t;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int HOLD_CYCLES = 3000;
    localparam int IDLE_WAIT   = 40;

    logic clk;
    logic rst_n;

    m4inv_req_if req_ch();
    m4inv_rsp_if rsp_ch();
    m4inv_cfg_if cfg_ch();

    matrix4_inverse_adjoint_unit u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    // Predictor state
    logic signed [ELEM_W-1:0] elem_store [16];
    logic [THR_W-1:0]         thr_model;
    inv_elem_t                inv_expect_q [$];

    int  fails;
    int  cycle_count;
    int  tx_idle_pct;
    int  rx_stall_pct;
    int  hold_cnt;
    logic hold_start;

    // Clock
    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // Abort a run that hangs
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("matrix4_inverse_adjoint_unit_test: FAIL");
            $finish;
        end
    end

    // Count down a long receiver hold-off
    always @(posedge clk)
    begin
        if (hold_start)
            hold_cnt <= HOLD_CYCLES;
        else if (hold_cnt > 0)
            hold_cnt <= hold_cnt - 1;
    end

    // Work out the inverse of the stored matrix and queue its result elements
    function automatic void predict_inverse();
        logic signed [127:0] k [3][3];
        logic signed [127:0] cof [4][4];
        logic signed [127:0] t;
        logic signed [127:0] det;
        logic [127:0]        mag;
        logic [127:0]        dmag;
        logic [127:0]        q;
        logic [127:0]        rem;
        logic [127:0]        lim;
        logic                neg;
        inv_elem_t           e;
        int                  a;
        int                  b;
        det = '0;
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
            begin
                a = 0;
                for (int i = 0; i < 4; i++)
                begin
                    if (i == r)
                        continue;
                    b = 0;
                    for (int j = 0; j < 4; j++)
                    begin
                        if (j == c)
                            continue;
                        k[a][b] = elem_store[i * 4 + j];
                        b++;
                    end
                    a++;
                end
                t = k[0][0] * (k[1][1] * k[2][2] - k[1][2] * k[2][1])
                  - k[0][1] * (k[1][0] * k[2][2] - k[1][2] * k[2][0])
                  + k[0][2] * (k[1][0] * k[2][1] - k[1][1] * k[2][0]);
                cof[r][c] = ((r + c) % 2 == 1) ? -t : t;
            end
        // Determinant from row-0 cofactors rounded to double scale
        for (int j = 0; j < 4; j++)
        begin
            mag = cof[0][j][127] ? -cof[0][j] : cof[0][j];
            mag = (mag + (128'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
            t = cof[0][j][127] ? -$signed(mag) : $signed(mag);
            det = det + t * $signed({{96{elem_store[j][31]}}, elem_store[j]});
        end
        dmag = det[127] ? -det : det;
        mag = (dmag + (128'd1 << (2 * FRAC_BITS - 1))) >> (2 * FRAC_BITS);
        if (det == 0 || mag < {97'd0, thr_model})
        begin
            e = '{value: '0, row: 2'd0, col: 2'd0, singular: 1'b1, overflow: 1'b0,
                  last: 1'b1};
            inv_expect_q.push_back(e);
            return;
        end
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++)
            begin
                neg = cof[j][i][127] != det[127];
                mag = cof[j][i][127] ? -cof[j][i] : cof[j][i];
                q = (mag << FRAC_BITS) / dmag;
                rem = (mag << FRAC_BITS) % dmag;
                if ((rem << 1) >= dmag)
                    q = q + 1;
                lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
                e.overflow = 1'b0;
                if (q > lim)
                begin
                    q = lim;
                    e.overflow = 1'b1;
                end
                q = neg ? -q : q;
                e.value = q[31:0];
                e.row = i[1:0];
                e.col = j[1:0];
                e.singular = 1'b0;
                e.last = (i == 3 && j == 3);
                inv_expect_q.push_back(e);
            end
    endfunction

    // Check each accepted result element against the oldest expectation
    task automatic check_result();
        inv_elem_t e;
        if (inv_expect_q.size() == 0)
        begin
            $display("%0t: unexpected result value %h row %0d col %0d", $time,
                     rsp_ch.inverse_value, rsp_ch.out_row, rsp_ch.out_col);
            fails++;
            return;
        end
        e = inv_expect_q.pop_front();
        if (rsp_ch.inverse_value !== e.value)
        begin
            $display("%0t: inverse_value expected %h actual %h", $time, e.value,
                     rsp_ch.inverse_value);
            fails++;
        end
        if (rsp_ch.out_row !== e.row)
        begin
            $display("%0t: out_row expected %0d actual %0d", $time, e.row, rsp_ch.out_row);
            fails++;
        end
        if (rsp_ch.out_col !== e.col)
        begin
            $display("%0t: out_col expected %0d actual %0d", $time, e.col, rsp_ch.out_col);
            fails++;
        end
        if (rsp_ch.singular !== e.singular)
        begin
            $display("%0t: singular expected %0d actual %0d", $time, e.singular,
                     rsp_ch.singular);
            fails++;
        end
        if (rsp_ch.overflow !== e.overflow)
        begin
            $display("%0t: overflow expected %0d actual %0d", $time, e.overflow,
                     rsp_ch.overflow);
            fails++;
        end
        if (rsp_ch.last_result !== e.last)
        begin
            $display("%0t: last_result expected %0d actual %0d", $time, e.last,
                     rsp_ch.last_result);
            fails++;
        end
    endtask

    // Receiver: take results, stall at random or during a hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
                check_result();
            rsp_ch.ready <= (hold_cnt == 0) && ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Offer one request and hold it until accepted; update the predictor on acceptance
    task automatic send_elem(input logic [31:0] value, input logic [1:0] row,
                             input logic [1:0] col, input logic last, input logic typed_sing);
        inv_elem_t e;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.element_value <= value;
        req_ch.elem_row      <= row;
        req_ch.elem_col      <= col;
        req_ch.last_element  <= last;
        do
            @(posedge clk);
        while (!req_ch.ready);
        elem_store[{row, col}] = value;
        if (last)
        begin
            if (typed_sing)
            begin
                e = '{value: '0, row: 2'd0, col: 2'd0, singular: 1'b1, overflow: 1'b0,
                      last: 1'b1};
                inv_expect_q.push_back(e);
            end
            else
                predict_inverse();
        end
    endtask

    // Drain, let the sequencer settle, then write the threshold
    task automatic write_threshold(input logic [THR_W-1:0] value);
        req_ch.valid <= 1'b0;
        while (inv_expect_q.size() != 0)
            @(posedge clk);
        repeat (IDLE_WAIT) @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        thr_model = value;
    endtask

    function automatic logic [31:0] rand_elem(input int style, input int r, input int c);
        logic [31:0] v;
        case (style)
            0:
            begin
                v = $urandom_range(131071) - 65536;
                if (r == c)
                    v = v + ($urandom_range(4, 1) << FRAC_BITS);
            end
            1: v = $urandom;
            2: v = $urandom_range(510) - 255;
            default:
                case ($urandom_range(4))
                    0: v = 32'h8000_0000;
                    1: v = 32'h7FFF_FFFF;
                    2: v = 32'h0000_0000;
                    3: v = 32'h0000_0001;
                    default: v = 32'hFFFF_FFFF;
                endcase
        endcase
        return v;
    endfunction

    // Random stimulus: mostly whole matrices in shuffled order, some partial updates
    task automatic random_phase(input int n_items);
        int sent;
        int kind;
        int style;
        int n;
        int order [16];
        int tmp;
        int x;
        sent = 0;
        while (sent < n_items)
        begin
            kind = $urandom_range(9);
            style = $urandom_range(3);
            if (kind < 7)
            begin
                for (int i = 0; i < 16; i++)
                    order[i] = i;
                for (int i = 15; i > 0; i--)
                begin
                    x = $urandom_range(i);
                    tmp = order[i];
                    order[i] = order[x];
                    order[x] = tmp;
                end
                for (int i = 0; i < 16; i++)
                    send_elem(rand_elem(style, order[i] / 4, order[i] % 4),
                              2'(order[i] / 4), 2'(order[i] % 4), i == 15, 1'b0);
                sent += 16;
            end
            else
            begin
                // Partial update ending in a last request when kind is 8, else loose writes
                n = $urandom_range(4, 1);
                for (int i = 0; i < n; i++)
                begin
                    x = $urandom_range(15);
                    send_elem(rand_elem(style, x / 4, x % 4), 2'(x / 4), 2'(x % 4),
                              (kind == 8) && (i == n - 1), 1'b0);
                end
                sent += n;
            end
        end
    endtask

    load_row_t load_table [$];

    initial
    begin
        load_row_t lr;
        rst_n = 1'b0;
        fails = 0;
        hold_start = 1'b0;
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        thr_model = THR_W'(1);
        req_ch.valid = 1'b0;
        req_ch.element_value = '0;
        req_ch.elem_row = '0;
        req_ch.elem_col = '0;
        req_ch.last_element = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        for (int i = 0; i < 16; i++)
            elem_store[i] = '0;

        // Directed loads: identity, zero determinant, extreme elements
        for (int i = 0; i < 16; i++)
        begin
            lr = '{value: (i / 4 == i % 4) ? 32'h0001_0000 : 32'h0, row: 2'(i / 4),
                   col: 2'(i % 4), last: i == 15, typed_singular: 1'b0};
            load_table.push_back(lr);
        end
        load_table.push_back('{32'h0000_0000, 2'd0, 2'd0, 1'b1, 1'b1});
        load_table.push_back('{32'h7FFF_FFFF, 2'd0, 2'd0, 1'b1, 1'b0});
        load_table.push_back('{32'h8000_0000, 2'd1, 2'd1, 1'b1, 1'b0});
        load_table.push_back('{32'h8000_0000, 2'd0, 2'd0, 1'b1, 1'b0});
        load_table.push_back('{32'h0000_0001, 2'd2, 2'd2, 1'b1, 1'b0});
        load_table.push_back('{32'hFFFF_FFFF, 2'd3, 2'd3, 1'b1, 1'b0});

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (load_table[i])
            send_elem(load_table[i].value, load_table[i].row, load_table[i].col,
                      load_table[i].last, load_table[i].typed_singular);

        // Threshold zero, no idling, with one long hold-off to back the unit up
        write_threshold('0);
        hold_start <= 1'b1;
        @(posedge clk);
        hold_start <= 1'b0;
        random_phase(60);

        // Largest threshold: only matrices with a large determinant pass; sender idles
        write_threshold({THR_W{1'b1}});
        tx_idle_pct = 52;
        random_phase(45);

        // Threshold one in fixed point; receiver stalls
        write_threshold(31'h0001_0000);
        tx_idle_pct = 0;
        rx_stall_pct = 52;
        random_phase(65);

        // Random threshold; both sides idle now and then
        write_threshold(THR_W'($urandom_range(32'h0002_0000)));
        tx_idle_pct = 11;
        rx_stall_pct = 11;
        random_phase(65);

        req_ch.valid <= 1'b0;
        while (inv_expect_q.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (fails == 0)
            $display("matrix4_inverse_adjoint_unit_test: PASS");
        else
            $display("matrix4_inverse_adjoint_unit_test: FAIL");
        $finish;
    end

endmodule
